[rtl/core/mau_pkg.sv]
// Package: opcodes, register indexes and shared types for the Montgomery unit
package mau_pkg;

    typedef enum logic [2:0] {
        OP_REDUCE = 3'd0,
        OP_MUL    = 3'd1,
        OP_ENCODE = 3'd2,
        OP_DECODE = 3'd3,
        OP_POWER  = 3'd4
    } opcode_t;

    localparam logic [1:0] REG_MODULUS     = 2'd0;
    localparam logic [1:0] REG_NEG_INVERSE = 2'd1;
    localparam logic [1:0] REG_R_SQUARED   = 2'd2;
    localparam logic [1:0] REG_NARROW_MODE = 2'd3;

    localparam int CFG_IDX_W = 3;

    // request from sequencer to the REDC engine
    typedef struct packed {
        logic        start;
        logic        narrow;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] mul_a;
        logic [63:0] mul_b;
        logic        do_mul;
    } redc_req_t;

endpackage

[rtl/core/montgomery_arith_unit.sv]
// Top level: Montgomery arithmetic unit with config registers and power sequencer
//
// channel | ports                         | direction
// s_      | s_valid/s_ready, opcode, ops  | in
// m_      | m_valid/m_ready, m_result     | out
// cfg     | cfg_we, cfg_index, cfg_data   | in
//
// One product pass runs on the shared 32x32 multiplier in three phases of four
// partial products, then add, subtract and done; a reduce-only pass skips the
// first phase. Multiply and encode take a product pass, reduce and decode a
// reduce-only pass. Power takes three passes plus one per exponent bit and one
// more per set exponent bit.
// Reset is synchronous, active low, and clears control.
// s_ready is low while an item is in work or its result waits for m_ready.
module montgomery_arith_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [mau_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [63:0] s_operand_hi,
    input  logic [63:0] s_operand_a,
    input  logic [63:0] s_operand_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result
);

    typedef enum logic [5:0] {
        T_IDLE = 6'b000001,
        T_ACC  = 6'b000010,
        T_SQ   = 6'b000100,
        T_LOOP = 6'b001000,
        T_LAST = 6'b010000,
        T_OUT  = 6'b100000
    } top_t;

    logic [63:0] modulus_reg, neg_inverse_reg;
    logic [62:0] r_squared_reg;
    logic        narrow_reg;
    top_t        st_reg, st_next;
    logic [63:0] e_reg, acc_reg, sq_reg, res_reg;
    logic        wait_reg;
    logic        mulsq_reg;
    mau_pkg::redc_req_t req;
    logic        done;
    logic [63:0] rres;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg     <= 64'd1;
            neg_inverse_reg <= '1;
            r_squared_reg   <= 63'd0;
            narrow_reg      <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                {1'b0, mau_pkg::REG_MODULUS}:     modulus_reg     <= cfg_data;
                {1'b0, mau_pkg::REG_NEG_INVERSE}: neg_inverse_reg <= cfg_data;
                {1'b0, mau_pkg::REG_R_SQUARED}:   r_squared_reg   <= cfg_data[62:0];
                {1'b0, mau_pkg::REG_NARROW_MODE}: narrow_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    mau_redc u_redc (
        .aclk(aclk), .aresetn(aresetn), .req(req),
        .modulus(modulus_reg), .neg_inverse(neg_inverse_reg),
        .done(done), .res(rres)
    );

    logic        accept;
    logic [63:0] r2;
    assign accept  = s_valid && s_ready;
    assign s_ready = (st_reg == T_IDLE);
    assign m_valid = (st_reg == T_OUT);
    assign m_result = res_reg;
    assign r2 = {1'b0, r_squared_reg};

    // build engine requests
    always_comb begin
        req = '0;
        req.narrow = narrow_reg;
        if (accept) begin
            req.start = (s_opcode <= mau_pkg::OP_POWER);
            req.hi = s_operand_hi;
            req.lo = s_operand_a;
            req.mul_a = (s_opcode == mau_pkg::OP_POWER) ? 64'd1 : s_operand_a;
            req.mul_b = (s_opcode == mau_pkg::OP_MUL) ? s_operand_b : r2;
            req.do_mul = (s_opcode == mau_pkg::OP_MUL) || (s_opcode == mau_pkg::OP_ENCODE)
                      || (s_opcode == mau_pkg::OP_POWER);
            if (s_opcode == mau_pkg::OP_DECODE) req.hi = 64'd0;
        end else if (!wait_reg) begin
            unique case (st_reg)
                // encode the held power base
                T_SQ: begin
                    req.start = 1'b1; req.do_mul = 1'b1;
                    req.mul_a = sq_reg; req.mul_b = r2;
                end
                T_LOOP: begin
                    req.start = 1'b1;
                    req.do_mul = (e_reg != 64'd0);
                    req.mul_a = mulsq_reg ? sq_reg : acc_reg;
                    req.mul_b = sq_reg;
                    req.lo = acc_reg;
                end
                default: ;
            endcase
        end
    end

    // sequence operations
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= T_IDLE;
            wait_reg <= 1'b0;
            mulsq_reg <= 1'b0;
        end else begin
            if (done) wait_reg <= 1'b0;
            else if (req.start) wait_reg <= 1'b1;
            unique case (st_reg)
                T_IDLE: if (accept) begin
                    e_reg <= s_operand_b;
                    sq_reg <= s_operand_a;
                    mulsq_reg <= 1'b0;
                    if (s_opcode > mau_pkg::OP_POWER) begin
                        res_reg <= 64'd0;
                        st_reg <= T_OUT;
                    end else begin
                        st_reg <= (s_opcode == mau_pkg::OP_POWER) ? T_ACC : T_LAST;
                    end
                end
                T_ACC: if (done) begin
                    acc_reg <= rres;
                    st_reg <= T_SQ;
                end
                T_SQ: if (done) begin
                    sq_reg <= rres;
                    st_reg <= T_LOOP;
                    mulsq_reg <= !e_reg[0];
                end
                T_LOOP: begin
                    if (done) begin
                        if (e_reg == 64'd0) begin
                            res_reg <= rres;
                            st_reg <= T_OUT;
                        end else if (!mulsq_reg) begin
                            acc_reg <= rres;
                            mulsq_reg <= 1'b1;
                        end else begin
                            sq_reg <= rres;
                            e_reg <= e_reg >> 1;
                            mulsq_reg <= !e_reg[1];
                        end
                    end
                end
                T_LAST: if (done) begin
                    res_reg <= rres;
                    st_reg <= T_OUT;
                end
                T_OUT: if (m_ready) st_reg <= T_IDLE;
                default: st_reg <= T_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        wait_reg |-> !req.start) else $error("engine restarted while busy");
    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result)))
        else $error("result changed while stalled");
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready while result pending");
`endif

endmodule

[rtl/core/mau_mul32.sv]
// Shared 32x32 multiplier with registered product
module mau_mul32 (
    input  logic        aclk,
    input  logic [31:0] x,
    input  logic [31:0] y,
    output logic [63:0] p_reg
);

    // register the product
    always_ff @(posedge aclk) begin
        p_reg <= {32'd0, x} * {32'd0, y};
    end

endmodule

[rtl/core/mau_redc.sv]
// Montgomery product / REDC engine built on one shared 32x32 multiplier
module mau_redc (
    input  logic              aclk,
    input  logic              aresetn,
    input  mau_pkg::redc_req_t req,
    input  logic [63:0]       modulus,
    input  logic [63:0]       neg_inverse,
    output logic              done,
    output logic [63:0]       res
);

    // one partial product per step; step list fixed per pass
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PROD  = 7'b0000010,
        S_MLO   = 7'b0000100,
        S_MQ    = 7'b0001000,
        S_ADD   = 7'b0010000,
        S_SUB   = 7'b0100000,
        S_DONE  = 7'b1000000
    } st_t;

    st_t         st_reg, st_next;
    logic [2:0]  k_reg, k_next;
    logic        narrow_reg;
    logic [63:0] a_reg, b_reg;
    logic [127:0] t_reg;
    logic [127:0] acc_reg;
    logic [63:0] m_reg;
    logic [63:0] u_reg;
    logic [31:0] mx, my;
    logic [63:0] p;
    logic [63:0] ea, eb;

    mau_mul32 u_mul (.aclk(aclk), .x(mx), .y(my), .p_reg(p));

    // pick limbs for the current partial product (k: bit1=a limb, bit0=b limb)
    always_comb begin
        ea = 64'd0;
        eb = 64'd0;
        unique case (st_reg)
            S_PROD: begin ea = a_reg; eb = b_reg; end
            S_MLO:  begin ea = t_reg[63:0]; eb = neg_inverse; end
            // narrow mode multiplies by the low half of the modulus only
            S_MQ:   begin
                ea = m_reg;
                eb = narrow_reg ? {32'd0, modulus[31:0]} : modulus;
            end
            default: begin ea = 64'd0; eb = 64'd0; end
        endcase
        mx = k_reg[1] ? ea[63:32] : ea[31:0];
        my = k_reg[0] ? eb[63:32] : eb[31:0];
    end

    // sequence partial products; the registered product arrives the cycle after its operands
    always_comb begin
        st_next = st_reg;
        k_next  = k_reg;
        unique case (st_reg)
            S_IDLE: if (req.start) begin
                st_next = req.do_mul ? S_PROD : S_MLO;
                k_next  = 3'd0;
            end
            S_PROD, S_MLO, S_MQ: begin
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd4) begin
                    k_next = 3'd0;
                    st_next = (st_reg == S_PROD) ? S_MLO :
                              (st_reg == S_MLO) ? S_MQ : S_ADD;
                end
            end
            S_ADD:  st_next = S_SUB;
            S_SUB:  st_next = S_DONE;
            S_DONE: st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    logic [127:0] pp;
    logic [1:0]   pk;
    assign pk = k_reg[1:0] - 2'd1;
    always_comb begin
        pp = 128'd0;
        unique case (pk)
            2'd0: pp = {64'd0, p};
            2'd1: pp = {32'd0, p, 32'd0};
            2'd2: pp = {32'd0, p, 32'd0};
            2'd3: pp = {p, 64'd0};
            default: pp = 128'd0;
        endcase
    end

    logic [127:0] sum_full;
    logic [63:0]  u_sub;
    logic [63:0]  qn;
    assign qn = narrow_reg ? {32'd0, modulus[31:0]} : modulus;
    assign sum_full = t_reg + acc_reg;
    assign u_sub = (u_reg >= qn) ? u_reg - qn : u_reg;

    // datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            k_reg  <= 3'd0;
        end else begin
            st_reg <= st_next;
            k_reg  <= k_next;
        end
        unique case (st_reg)
            S_IDLE: begin
                narrow_reg <= req.narrow;
                a_reg <= req.narrow ? {32'd0, req.mul_a[31:0]} : req.mul_a;
                b_reg <= req.narrow ? {32'd0, req.mul_b[31:0]} : req.mul_b;
                t_reg <= req.narrow ? {64'd0, req.lo} : {req.hi, req.lo};
                acc_reg <= 128'd0;
            end
            S_PROD, S_MLO, S_MQ: begin
                if (k_reg == 3'd4) begin
                    if (st_reg == S_PROD) begin
                        t_reg <= narrow_reg ? {64'd0, acc_reg[63:0] + pp[63:0]}
                                            : acc_reg + pp;
                    end else if (st_reg == S_MLO) begin
                        m_reg <= narrow_reg ? {32'd0, acc_reg[31:0] + pp[31:0]}
                                            : acc_reg[63:0] + pp[63:0];
                    end
                    acc_reg <= (st_reg == S_MQ) ? acc_reg + pp : 128'd0;
                end else if (k_reg != 3'd0) begin
                    acc_reg <= acc_reg + pp;
                end
            end
            S_ADD: begin
                if (narrow_reg)
                    u_reg <= {31'd0, (t_reg[63:0] + acc_reg[63:0]) < t_reg[63:0],
                              sum_full[63:32]};
                else
                    u_reg <= sum_full[127:64];
            end
            S_SUB: u_reg <= narrow_reg ? {32'd0, u_sub[31:0]} : u_sub;
            default: ;
        endcase
    end

    assign done = (st_reg == S_DONE);
    assign res  = u_reg;

endmodule
